// File: hdl/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types and constants of the heightmap bilinear sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

    // Grid geometry
    localparam int GRID_COLS = 128;
    localparam int GRID_ROWS = 128;
    localparam int CELLS     = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int XW        = $clog2(GRID_COLS);
    localparam int YW        = $clog2(GRID_ROWS);

    // Step counts of the sequenced units
    localparam int CNT_W      = 6;
    localparam int CORNERS    = 4;
    localparam int DIV_STEPS  = 32;
    localparam int SQRT_STEPS = 16;
    localparam int POLY_STEPS = 5;

    // Operation codes
    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [1:0] FUNC_HILL   = 2'd2;

    // Request beat
    typedef struct packed {
        logic [1:0]         func;
        logic [6:0]         cell_x;
        logic [6:0]         cell_y;
        logic signed [15:0] cell_height;
        logic [14:0]        sample_x;
        logic [14:0]        sample_y;
        logic [6:0]         hill_radius;
        logic signed [15:0] hill_amplitude;
    } req_t;

    // Response beat
    typedef struct packed {
        logic signed [15:0] height_out;
        logic               in_range;
        logic               saturated;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_en;
        logic load;
        logic cnt_clr;
        logic corner_rd;
        logic corner_acc;
        logic cell_init;
        logic cell_next;
        logic div_step;
        logic sqrt_step;
        logic poly_step;
        logic amp_step;
        logic wr_step;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0]       req_func;
        logic             req_sinr;
        logic             req_hill_skip;
        logic             clr_last;
        logic [CNT_W-1:0] cnt;
        logic             cell_in;
        logic             cell_last;
        logic             out_free;
    } sts_t;

endpackage

// File: hdl/hbs_ram.sv
// ----------------------------------------------------------------------------
// hbs_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module hbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/hbs_ctrl.sv
// ----------------------------------------------------------------------------
// hbs_ctrl
// Sequencer: clearing sweep, sample corner reads, hill cell walk.
// ----------------------------------------------------------------------------
module hbs_ctrl
    import hbs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_SRD   = 4'd2;
    localparam logic [3:0] ST_SACC  = 4'd3;
    localparam logic [3:0] ST_HCELL = 4'd4;
    localparam logic [3:0] ST_HDIV  = 4'd5;
    localparam logic [3:0] ST_HSQRT = 4'd6;
    localparam logic [3:0] ST_HPOLY = 4'd7;
    localparam logic [3:0] ST_HAMP  = 4'd8;
    localparam logic [3:0] ST_HWR   = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign req_stall = (state_reg != ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load    = 1'b1;
                    cmd.cnt_clr = 1'b1;
                    unique case (sts.req_func)
                        FUNC_SAMPLE: state_next = sts.req_sinr ? ST_SRD : ST_DONE;
                        FUNC_HILL:   state_next = sts.req_hill_skip ? ST_DONE : ST_HCELL;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_SRD:
            begin
                cmd.corner_rd  = 1'b1;
                cmd.corner_acc = (sts.cnt != '0);
                if (sts.cnt == CNT_W'(CORNERS - 1))
                begin
                    state_next = ST_SACC;
                end
            end
            ST_SACC:
            begin
                cmd.corner_acc = 1'b1;
                state_next     = ST_DONE;
            end
            ST_HCELL:
            begin
                cmd.cell_init = 1'b1;
                cmd.cnt_clr   = 1'b1;
                if (sts.cell_in)
                begin
                    state_next = ST_HDIV;
                end
                else
                begin
                    cmd.cell_next = 1'b1;
                    if (sts.cell_last)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_HDIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.cnt == CNT_W'(DIV_STEPS - 1))
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_HSQRT;
                end
            end
            ST_HSQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.cnt == CNT_W'(SQRT_STEPS - 1))
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_HPOLY;
                end
            end
            ST_HPOLY:
            begin
                cmd.poly_step = 1'b1;
                if (sts.cnt == CNT_W'(POLY_STEPS - 1))
                begin
                    state_next = ST_HAMP;
                end
            end
            ST_HAMP:
            begin
                cmd.amp_step = 1'b1;
                state_next   = ST_HWR;
            end
            ST_HWR:
            begin
                cmd.wr_step   = 1'b1;
                cmd.cell_next = 1'b1;
                state_next    = sts.cell_last ? ST_DONE : ST_HCELL;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/hbs_dpath.sv
// ----------------------------------------------------------------------------
// hbs_dpath
// Height store, bilinear accumulator, hill shape unit (divider, square
// root, cosine polynomial) and the response register.
// ----------------------------------------------------------------------------
module hbs_dpath
    import hbs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int HW  = ((XW > YW) ? ((XW > 8) ? XW : 8) : ((YW > 8) ? YW : 8)) + 2;
    localparam int D2W = 15;
    localparam logic signed [HW-1:0] H_ONE = HW'(1);
    localparam logic signed [HW-1:0] X_MAX = HW'(GRID_COLS - 1);
    localparam logic signed [HW-1:0] Y_MAX = HW'(GRID_ROWS - 1);
    localparam int SX_LIMIT = (GRID_COLS - 1) * 256;
    localparam int SY_LIMIT = (GRID_ROWS - 1) * 256;
    localparam logic [16:0] COS_K0 = 17'd60;
    localparam logic [16:0] COS_K1 = 17'd1367;
    localparam logic [16:0] COS_K2 = 17'd16624;
    localparam logic [16:0] COS_K3 = 17'd80852;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [XW-1:0] x,
                                                    input logic [YW-1:0] y);
        return ADDR_W'(y) * ADDR_W'(GRID_COLS) + ADDR_W'(x);
    endfunction

    // Registers
    req_t               in_reg;
    logic               inr_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [16:0]        w_reg;
    logic signed [33:0] acc_reg;
    logic [XW-1:0]      i_reg, ilo_reg, ihi_reg;
    logic [YW-1:0]      j_reg, jhi_reg;
    logic [13:0]        r2_reg;
    logic [D2W-1:0]     rem_reg;
    logic [31:0]        q_reg;
    logic [31:0]        sv_reg, sres_reg;
    logic [33:0]        prod_reg;
    logic [15:0]        u_reg;
    logic signed [33:0] ap_reg;
    logic               sat_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic [15:0]        ram_rdata;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [15:0]        ram_wdata;

    // Request decode: sample range and clipped hill box
    logic               req_sinr, req_in_grid;
    logic signed [HW-1:0] xc_s, yc_s, r_s, xlo_raw, xhi_raw, ylo_raw, yhi_raw;
    logic signed [HW-1:0] xlo_s, xhi_s, ylo_s, yhi_s;

    assign req_sinr = (req.sample_x != '0) && (32'(req.sample_x) < SX_LIMIT)
                   && (req.sample_y != '0) && (32'(req.sample_y) < SY_LIMIT);
    assign req_in_grid = (32'(req.cell_x) < GRID_COLS) && (32'(req.cell_y) < GRID_ROWS);
    assign xc_s    = HW'(req.cell_x);
    assign yc_s    = HW'(req.cell_y);
    assign r_s     = HW'(req.hill_radius);
    assign xlo_raw = xc_s - r_s;
    assign xhi_raw = xc_s + r_s;
    assign ylo_raw = yc_s - r_s;
    assign yhi_raw = yc_s + r_s;
    assign xlo_s   = (xlo_raw < H_ONE) ? H_ONE : xlo_raw;
    assign xhi_s   = (xhi_raw > X_MAX) ? X_MAX : xhi_raw;
    assign ylo_s   = (ylo_raw < H_ONE) ? H_ONE : ylo_raw;
    assign yhi_s   = (yhi_raw > Y_MAX) ? Y_MAX : yhi_raw;

    // Sample corner address and weight
    logic [XW-1:0] xi, cx_c;
    logic [YW-1:0] yi, cy_c;
    logic [7:0]    fx, fy;
    logic [8:0]    wx, wy;
    logic [16:0]   w_c;
    logic [ADDR_W-1:0] corner_addr;

    assign xi   = XW'(in_reg.sample_x[14:8]);
    assign yi   = YW'(in_reg.sample_y[14:8]);
    assign fx   = in_reg.sample_x[7:0];
    assign fy   = in_reg.sample_y[7:0];
    assign cx_c = xi + XW'(cnt_reg[0]);
    assign cy_c = yi + YW'(cnt_reg[1]);
    assign wx   = cnt_reg[0] ? {1'b0, fx} : (9'd256 - {1'b0, fx});
    assign wy   = cnt_reg[1] ? {1'b0, fy} : (9'd256 - {1'b0, fy});
    assign w_c  = wx * wy;
    assign corner_addr = cell_addr(cx_c, cy_c);

    // Weighted corner and rounded result
    logic signed [33:0] corner_prod, acc_rnd;
    assign corner_prod = $signed(ram_rdata) * $signed({1'b0, w_reg});
    assign acc_rnd     = acc_reg + 34'sd32768;

    // Hill cell distance
    logic signed [HW-1:0]   i_s, j_s, di, dj;
    logic signed [2*HW-1:0] di2, dj2, d2_sum;
    logic [D2W-1:0]         d2;
    logic                   cell_in, cell_last;

    assign i_s    = HW'(i_reg);
    assign j_s    = HW'(j_reg);
    assign di     = i_s - HW'(in_reg.cell_x);
    assign dj     = j_s - HW'(in_reg.cell_y);
    assign di2    = di * di;
    assign dj2    = dj * dj;
    assign d2_sum = di2 + dj2;
    assign d2     = d2_sum[D2W-1:0];
    assign cell_in   = (d2 < D2W'(r2_reg));
    assign cell_last = (i_reg == ihi_reg) && (j_reg == jhi_reg);

    // Restoring divider step: (d2 << 32) / r2
    logic [D2W:0]   div_sh, div_diff;
    logic           div_bit;
    assign div_sh   = {rem_reg, 1'b0};
    assign div_bit  = (div_sh >= (D2W + 1)'(r2_reg));
    assign div_diff = div_sh - (D2W + 1)'(r2_reg);

    // Square root step, two bits of radicand per cycle
    logic [31:0] sq_v, sq_r, sq_bit, sq_trial;
    logic        sq_take;
    assign sq_v     = (cnt_reg == '0) ? q_reg : sv_reg;
    assign sq_r     = (cnt_reg == '0) ? 32'd0 : sres_reg;
    assign sq_bit   = 32'h4000_0000 >> {cnt_reg[3:0], 1'b0};
    assign sq_trial = sq_r + sq_bit;
    assign sq_take  = (sq_v >= sq_trial);

    // Cosine polynomial: one shared multiplier, one product per step
    logic [15:0] u_now;
    logic [16:0] poly_k, p_c, ma, mb;
    logic [17:0] p_w;
    logic [33:0] mprod;
    assign u_now = prod_reg[31:16];

    always_comb
    begin
        if (cnt_reg == CNT_W'(2))
        begin
            poly_k = COS_K1;
        end
        else if (cnt_reg == CNT_W'(3))
        begin
            poly_k = COS_K2;
        end
        else
        begin
            poly_k = COS_K3;
        end
        p_w = {1'b0, poly_k} - prod_reg[33:16];
        p_c = p_w[16:0];
        if (cnt_reg == '0)
        begin
            ma = {1'b0, sres_reg[15:0]};
            mb = {1'b0, sres_reg[15:0]};
        end
        else if (cnt_reg == CNT_W'(1))
        begin
            ma = COS_K0;
            mb = {1'b0, u_now};
        end
        else
        begin
            ma = p_c;
            mb = {1'b0, u_reg};
        end
    end
    assign mprod = ma * mb;

    // Cosine clamp, amplitude scale, saturating add
    logic signed [18:0] c_s;
    logic [16:0]        c_q;
    logic signed [33:0] amp_prod, ap_rnd;
    logic signed [18:0] add_s, nv;
    logic [15:0]        nv_sat;
    logic               nv_clip;

    assign c_s      = 19'sd65536 - $signed({1'b0, prod_reg[33:16]});
    assign c_q      = (c_s < 0) ? 17'd0 : c_s[16:0];
    assign amp_prod = in_reg.hill_amplitude * $signed({1'b0, c_q});
    assign ap_rnd   = ap_reg + 34'sd32768;
    assign add_s    = 19'($signed(ap_rnd[33:16]));
    assign nv       = 19'($signed(ram_rdata)) + add_s;

    always_comb
    begin
        nv_clip = 1'b1;
        priority if (nv > 19'sd32767)
        begin
            nv_sat = 16'h7FFF;
        end
        else if (nv < -19'sd32768)
        begin
            nv_sat = 16'h8000;
        end
        else
        begin
            nv_sat  = nv[15:0];
            nv_clip = 1'b0;
        end
    end

    // Store port selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = '0;
        ram_wdata = '0;
        priority if (cmd.clear_en)
        begin
            ram_we   = 1'b1;
            ram_addr = clr_addr_reg;
        end
        else if (cmd.load)
        begin
            ram_we    = (req.func == FUNC_WRITE) && req_in_grid;
            ram_addr  = cell_addr(XW'(req.cell_x), YW'(req.cell_y));
            ram_wdata = req.cell_height;
        end
        else if (cmd.corner_rd)
        begin
            ram_addr = corner_addr;
        end
        else
        begin
            ram_we    = cmd.wr_step;
            ram_addr  = cell_addr(i_reg, j_reg);
            ram_wdata = nv_sat;
        end
    end

    hbs_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Control registers: clear sweep, step counter, response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_en)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.corner_rd || cmd.div_step || cmd.sqrt_step || cmd.poly_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg  <= req;
            inr_reg <= req_sinr;
            acc_reg <= '0;
            sat_reg <= 1'b0;
            r2_reg  <= req.hill_radius * req.hill_radius;
            i_reg   <= xlo_s[XW-1:0];
            ilo_reg <= xlo_s[XW-1:0];
            ihi_reg <= xhi_s[XW-1:0];
            j_reg   <= ylo_s[YW-1:0];
            jhi_reg <= yhi_s[YW-1:0];
        end
        if (cmd.corner_rd)
        begin
            w_reg <= w_c;
        end
        if (cmd.corner_acc)
        begin
            acc_reg <= acc_reg + corner_prod;
        end
        if (cmd.cell_init)
        begin
            rem_reg <= d2;
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_bit ? div_diff[D2W-1:0] : div_sh[D2W-1:0];
            q_reg   <= {q_reg[30:0], div_bit};
        end
        if (cmd.sqrt_step)
        begin
            sv_reg   <= sq_take ? (sq_v - sq_trial) : sq_v;
            sres_reg <= sq_take ? ((sq_r >> 1) + sq_bit) : (sq_r >> 1);
        end
        if (cmd.poly_step)
        begin
            prod_reg <= mprod;
            if (cnt_reg == CNT_W'(1))
            begin
                u_reg <= u_now;
            end
        end
        if (cmd.amp_step)
        begin
            ap_reg <= amp_prod;
        end
        if (cmd.wr_step && nv_clip)
        begin
            sat_reg <= 1'b1;
        end
        if (cmd.cell_next)
        begin
            if (i_reg == ihi_reg)
            begin
                i_reg <= ilo_reg;
                j_reg <= j_reg + 1'b1;
            end
            else
            begin
                i_reg <= i_reg + 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            rsp_reg.height_out <= ((in_reg.func == FUNC_SAMPLE) && inr_reg)
                                  ? $signed(acc_rnd[31:16]) : 16'sd0;
            rsp_reg.in_range   <= (in_reg.func == FUNC_SAMPLE) && inr_reg;
            rsp_reg.saturated  <= (in_reg.func == FUNC_HILL) && sat_reg;
        end
    end

    // Status
    assign sts.req_func      = req.func;
    assign sts.req_sinr      = req_sinr;
    assign sts.req_hill_skip = (req.hill_radius == '0) || (xlo_s > xhi_s) || (ylo_s > yhi_s);
    assign sts.clr_last      = (clr_addr_reg == ADDR_W'(CELLS - 1));
    assign sts.cnt           = cnt_reg;
    assign sts.cell_in       = cell_in;
    assign sts.cell_last     = cell_last;
    assign sts.out_free      = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: hdl/heightmap_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler
// Square grid of signed Q7.8 heights: cell write, bilinear sample and
// cosine hill stamp with saturating adds.
// ----------------------------------------------------------------------------
//  channel  beat    handshake               contents
//  req      req_t   req_valid / req_stall   operation and its operands
//  rsp      rsp_t   rsp_valid / rsp_stall   height, in_range, saturated
//
//  Write, and a sample out of range, go straight to the response register.
//  Sample in range: four reads on the single store port, one corner per cycle.
//  Hill: each box cell outside the radius is skipped; each cell inside it
//  runs a 32-step divider, 16-step square root, 5 polynomial products and a
//  read-modify-write on the store port.
//  After reset a clearing pass zeroes the store while req is stalled.
//  A finished beat waits in the rsp register; the next req is taken meanwhile.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler
    import hbs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    cmd_t cmd;
    sts_t sts;

    hbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    hbs_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // No req beat taken while the store is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_en |-> req_stall)
        else $error("req accepted during clearing pass");

    // One item at a time: an accepted beat closes the req side
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("req side open after accepting a beat");

    // Only one user of the store port per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear_en, cmd.load, cmd.corner_rd, cmd.amp_step, cmd.wr_step}))
        else $error("store port claimed twice");

    // A sample never reports saturation
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.in_range && rsp.saturated))
        else $error("rsp flags in_range and saturated together");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the heightmap bilinear sampler: a scoreboard keeps
// its own height grid, predicts every response beat and compares it field by
// field, while random gaps and stalls exercise both handshakes.
// ----------------------------------------------------------------------------
module tb_top;
    import hbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Unused operation code: no effect, all-zero response
    localparam logic [1:0] FUNC_IDLE = 2'd3;
    localparam int RANDOM_ITEMS = 1300;
    localparam longint CYCLE_LIMIT = 40_000_000;

    // ------------------------------------------------------------------------
    // Grid model and expected-response store
    // ------------------------------------------------------------------------
    class height_scoreboard;
        shortint grid [CELLS];
        rsp_t    rsp_fifo [$];
        int      errors;
        int      n_rsp;
        int      n_inr;
        int      n_sat;

        function void clear_grid();
            foreach (grid[k]) grid[k] = 0;
        endfunction

        // floor((v + 32768) / 65536)
        function automatic longint round16(longint v);
            return (v + 64'sd32768) >>> 16;
        endfunction

        function automatic longint unsigned root64(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > v) b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        // cosine of the normalized distance, Q1.16
        function automatic longint hill_gain(longint unsigned d2, longint unsigned r2);
            longint unsigned t;
            longint u;
            longint p;
            longint c;
            t = root64((d2 << 32) / r2);
            u = longint'((t * t) >> 16);
            p = 60;
            p = 1367 - ((p * u) >>> 16);
            p = 16624 - ((p * u) >>> 16);
            p = 80852 - ((p * u) >>> 16);
            c = 65536 - ((p * u) >>> 16);
            if (c < 0) c = 0;
            if (c > 65536) c = 65536;
            return c;
        endfunction

        function automatic bit stamp(int xc, int yc, int r, longint amp);
            bit sat;
            longint nv;
            int di;
            int dj;
            sat = 0;
            if (r == 0) return 0;
            for (int i = xc - r; i <= xc + r; i++)
                for (int j = yc - r; j <= yc + r; j++)
                begin
                    di = i - xc;
                    dj = j - yc;
                    if (i <= 0 || i >= GRID_COLS || j <= 0 || j >= GRID_ROWS) continue;
                    if (di * di + dj * dj >= r * r) continue;
                    nv = longint'(grid[j * GRID_COLS + i]) +
                         round16(amp * hill_gain(longint'(di * di + dj * dj),
                                                 longint'(r * r)));
                    if (nv > 32767) begin nv = 32767; sat = 1; end
                    if (nv < -32768) begin nv = -32768; sat = 1; end
                    grid[j * GRID_COLS + i] = shortint'(nv);
                end
            return sat;
        endfunction

        // Note an accepted request beat and queue its expected response
        function void note_request(req_t q);
            rsp_t e;
            int x;
            int y;
            int xi;
            int yi;
            longint fx;
            longint fy;
            longint a;
            longint b;
            e = '0;
            x = int'(q.sample_x);
            y = int'(q.sample_y);
            case (q.func)
                FUNC_WRITE:
                    grid[int'(q.cell_y) * GRID_COLS + int'(q.cell_x)] = q.cell_height;
                FUNC_SAMPLE:
                    if (x > 0 && x < (GRID_COLS - 1) * 256 && y > 0 && y < (GRID_ROWS - 1) * 256)
                    begin
                        xi = x >> 8;
                        yi = y >> 8;
                        fx = x & 255;
                        fy = y & 255;
                        a = (256 - fx) * grid[yi * GRID_COLS + xi] +
                            fx * grid[yi * GRID_COLS + xi + 1];
                        b = (256 - fx) * grid[(yi + 1) * GRID_COLS + xi] +
                            fx * grid[(yi + 1) * GRID_COLS + xi + 1];
                        e.height_out = 16'(round16((256 - fy) * a + fy * b));
                        e.in_range = 1'b1;
                    end
                FUNC_HILL:
                    e.saturated = stamp(int'(q.cell_x), int'(q.cell_y), int'(q.hill_radius),
                                        longint'(q.hill_amplitude));
                default: ;
            endcase
            rsp_fifo.push_back(e);
        endfunction

        // Compare a response beat with the oldest expectation
        function void check_response(rsp_t r);
            rsp_t e;
            if (rsp_fifo.size() == 0)
            begin
                $error("unexpected response beat %h", r);
                errors++;
                return;
            end
            e = rsp_fifo.pop_front();
            n_rsp++;
            if (e.in_range) n_inr++;
            if (e.saturated) n_sat++;
            if (r.height_out !== e.height_out)
            begin
                $error("height_out: expected %0d, got %0d", e.height_out, r.height_out);
                errors++;
            end
            if (r.in_range !== e.in_range)
            begin
                $error("in_range: expected %0b, got %0b", e.in_range, r.in_range);
                errors++;
            end
            if (r.saturated !== e.saturated)
            begin
                $error("saturated: expected %0b, got %0b", e.saturated, r.saturated);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;
    longint cycles = 0;
    height_scoreboard sb;

    heightmap_bilinear_sampler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Random gap: mostly none or short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Beat monitor and cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (req_valid && !req_stall) sb.note_request(req);
            if (rsp_valid && !rsp_stall) sb.check_response(rsp);
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Response stall: bursty, with quiet stretches
    initial
    begin
        int calm;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            calm = $urandom_range(0, 3);
            repeat ($urandom_range(5, 60))
            begin
                @(posedge clk);
                if (calm != 0 && $urandom_range(0, 19) == 0)
                begin
                    rsp_stall <= 1'b1;
                    repeat (1 + gap_len()) @(posedge clk);
                    rsp_stall <= 1'b0;
                end
                else
                begin
                    rsp_stall <= (calm != 0) ? 1'b0 : ($urandom_range(0, 2) == 0);
                end
            end
        end
    end

    // Present one request beat and hold it until it is taken
    task automatic send(req_t q, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0)
        begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= q;
        do @(posedge clk); while (req_stall);
    endtask

    function automatic req_t mk(logic [1:0] f);
        req_t q;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        q = raw[$bits(req_t)-1:0];
        q.func = f;
        return q;
    endfunction

    task automatic send_write(int x, int y, int h);
        req_t q;
        q = mk(FUNC_WRITE);
        q.cell_x = 7'(x);
        q.cell_y = 7'(y);
        q.cell_height = 16'(h);
        send(q, 0);
    endtask

    task automatic send_sample(int x, int y);
        req_t q;
        q = mk(FUNC_SAMPLE);
        q.sample_x = 15'(x);
        q.sample_y = 15'(y);
        send(q, 0);
    endtask

    task automatic send_hill(int x, int y, int r, int a);
        req_t q;
        q = mk(FUNC_HILL);
        q.cell_x = 7'(x);
        q.cell_y = 7'(y);
        q.hill_radius = 7'(r);
        q.hill_amplitude = 16'(a);
        send(q, 0);
    endtask

    // Stimulus
    initial
    begin
        req_t q;
        int k;
        int sel;
        bit near;
        sb = new();
        sb.clear_grid();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes and each special case
        send_write(0, 0, -32768);
        send_write(127, 127, 32767);
        send_write(5, 5, 32767);
        send_write(6, 5, -32768);
        send_write(5, 6, 1000);
        send_write(6, 6, -1000);
        send_sample(5 * 256 + 128, 5 * 256 + 128);
        send_sample(5 * 256 + 255, 5 * 256 + 1);
        send_sample(0, 300);
        send_sample(300, 0);
        send_sample(32511, 32511);
        send_sample(32512, 300);
        send_sample(300, 32767);
        send_hill(5, 5, 0, 32767);
        send_hill(5, 5, 3, 32767);
        send_hill(6, 5, 2, -32768);
        send_hill(0, 0, 4, 2000);
        send_hill(127, 127, 3, -500);
        send_hill(0, 0, 127, 100);
        q = mk(FUNC_IDLE);
        send(q, 0);
        send_sample(1, 1);
        send_sample(5 * 256 + 3, 5 * 256 + 200);

        // Random: focus most traffic on a small patch so reads see writes
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == RANDOM_ITEMS / 2)
            begin
                req_valid <= 1'b0;
                while (sb.rsp_fifo.size() != 0) @(posedge clk);
            end
            sel = $urandom_range(0, 99);
            near = ($urandom_range(0, 3) != 0);
            if (sel < 35) q = mk(FUNC_WRITE);
            else if (sel < 80) q = mk(FUNC_SAMPLE);
            else if (sel < 95) q = mk(FUNC_HILL);
            else q = mk(FUNC_IDLE);
            if (near)
            begin
                q.cell_x = 7'($urandom_range(0, 15));
                q.cell_y = 7'($urandom_range(0, 15));
                q.sample_x = 15'($urandom_range(0, 16 * 256 - 1));
                q.sample_y = 15'($urandom_range(0, 16 * 256 - 1));
            end
            if (q.func == FUNC_HILL)
                q.hill_radius = ($urandom_range(0, 49) == 0) ?
                                7'($urandom_range(7, 16)) : 7'($urandom_range(0, 6));
            send(q, $urandom_range(0, 4) == 0);
        end
        req_valid <= 1'b0;

        // Drain
        while (sb.rsp_fifo.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Covered %0d responses: %0d in-range samples, %0d saturating hills.",
                 sb.n_rsp, sb.n_inr, sb.n_sat);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
